// ----- hw/rtl/lpht_pkg.sv -----
// ============================================================================
// lpht_pkg
// Shared types and constants for the linear probing table.
// ============================================================================
package lpht_pkg;

    localparam int CAPACITY_DEFAULT = 1024;
    localparam logic [9:0] MAX_ENTRIES_RESET = 10'd716;
    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_UPDATED   = 3'd3,
        ST_REJECTED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REJECT = 2'd2,
        CMD_MISS   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic [63:0] value_low;
        logic [63:0] value_high;
        logic [63:0] hash;
    } job_t;

    typedef enum logic [2:0] {
        FE_IDLE,
        FE_MIX,
        FE_MUL1,
        FE_MUL2,
        FE_PUSH
    } fe_state_t;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_HOME,
        BE_READ,
        BE_CHECK,
        BE_DONE,
        BE_CLEAR
    } be_state_t;

endpackage

// ----- hw/rtl/lpht_front.sv -----
// ============================================================================
// lpht_front
// Accepts requests, classifies them and computes the splitmix64 hash with a
// shared 32x32 multiplier that sums three partial products per 64-bit product.
// ============================================================================
module lpht_front
    import lpht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [63:0] key_low,
    input  logic [63:0] key_high,
    input  logic [63:0] value_low,
    input  logic [63:0] value_high,
    output logic        push,
    output job_t        job,
    input  logic        full
);

    fe_state_t   state_reg, state_next;
    logic        round_reg, round_next;
    logic [1:0]  part_reg, part_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    job_t        job_reg, job_next;

    logic [63:0] mul_const;
    logic [31:0] a_half, b_half;
    logic [63:0] prod;
    logic [63:0] prod_shift;

    always_comb
    begin
        mul_const = (state_reg == FE_MUL1) ? MIX_MUL1 : MIX_MUL2;
        a_half = part_reg[0] ? x_reg[63:32] : x_reg[31:0];
        b_half = part_reg[1] ? mul_const[63:32] : mul_const[31:0];
        prod = a_half * b_half;
        case (part_reg)
            2'd0:    prod_shift = prod;
            2'd1:    prod_shift = {prod[31:0], 32'd0};
            2'd2:    prod_shift = {prod[31:0], 32'd0};
            default: prod_shift = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        round_reg <= round_next;
        part_reg  <= part_next;
        x_reg     <= x_next;
        acc_reg   <= acc_next;
        job_reg   <= job_next;
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        part_next  = part_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        job_next   = job_reg;
        busy       = (state_reg != FE_IDLE);
        push       = 1'b0;
        job        = job_reg;
        case (state_reg)
            FE_IDLE:
            begin
                if (start)
                begin
                    job_next.key_low    = key_low;
                    job_next.key_high   = key_high;
                    job_next.value_low  = value_low;
                    job_next.value_high = value_high;
                    if (&{key_low, key_high})
                    begin
                        job_next.cmd = operation ? CMD_REJECT : CMD_MISS;
                    end
                    else
                    begin
                        job_next.cmd = operation ? CMD_INSERT : CMD_LOOKUP;
                    end
                    x_next     = key_high + GOLDEN;
                    round_next = 1'b0;
                    state_next = FE_MIX;
                end
            end
            FE_MIX:
            begin
                x_next     = (x_reg + GOLDEN) ^ ((x_reg + GOLDEN) >> 30);
                part_next  = 2'd0;
                acc_next   = 64'd0;
                state_next = FE_MUL1;
            end
            FE_MUL1:
            begin
                acc_next  = acc_reg + prod_shift;
                part_next = part_reg + 2'd1;
                if (part_reg == 2'd2)
                begin
                    x_next     = (acc_reg + prod_shift) ^ ((acc_reg + prod_shift) >> 27);
                    part_next  = 2'd0;
                    acc_next   = 64'd0;
                    state_next = FE_MUL2;
                end
            end
            FE_MUL2:
            begin
                acc_next  = acc_reg + prod_shift;
                part_next = part_reg + 2'd1;
                if (part_reg == 2'd2)
                begin
                    x_next = (acc_reg + prod_shift) ^ ((acc_reg + prod_shift) >> 31);
                    if (!round_reg)
                    begin
                        x_next     = job_reg.key_low ^ x_next;
                        round_next = 1'b1;
                        state_next = FE_MIX;
                    end
                    else
                    begin
                        job_next.hash = x_next;
                        state_next    = FE_PUSH;
                    end
                end
            end
            FE_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = FE_IDLE;
                end
            end
            default:
            begin
                state_next = FE_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/lpht_queue.sv -----
// ============================================================================
// lpht_queue
// Short first-in first-out queue of classified jobs between front and back.
// ============================================================================
module lpht_queue
    import lpht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic empty
);

    job_t       mem_reg [QUEUE_DEPTH];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/lpht_back.sv -----
// ============================================================================
// lpht_back
// Reduces the hash of a lookup or insert to a home slot, probes the slot memory
// linearly and answers each job with one result.
// ============================================================================
module lpht_back
    import lpht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [9:0]  max_entries,
    input  logic        empty,
    input  job_t        job,
    output logic        pop,
    output logic        done,
    output logic [2:0]  status,
    output logic [63:0] result_low,
    output logic [63:0] result_high
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int CNTW = (CW > 10) ? CW : 11;
    localparam logic [63:0] RECIP = 64'((65'd1 << 64) / 65'(CAPACITY));
    localparam logic [31:0] CAP32 = 32'(CAPACITY);

    be_state_t        state_reg, state_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    steps_reg, steps_next;
    logic [127:0]     acc_reg, acc_next;
    logic [31:0]      rem_reg, rem_next;
    logic [2:0]       step_reg, step_next;
    logic [CNTW-1:0]  count_reg, count_next;
    job_t             cur_reg, cur_next;
    logic             done_reg, done_next;
    logic [2:0]       status_reg, status_next;
    logic [63:0]      rlo_reg, rlo_next;
    logic [63:0]      rhi_reg, rhi_next;

    logic [256:0]     mem_key [CAPACITY];
    logic [256:0]     rd_data;
    logic [256:0]     wr_word;
    logic             wr_en;
    logic [31:0]      a_half, b_half;
    logic [63:0]      prod;
    logic [127:0]     prod_wide;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_key[idx_reg] <= wr_word;
        end
        rd_data <= mem_key[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_CLEAR;
            idx_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg  <= steps_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        rlo_reg    <= rlo_next;
        rhi_reg    <= rhi_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign result_low  = rlo_reg;
    assign result_high = rhi_reg;

    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                a_half = cur_reg.hash[31:0];
                b_half = RECIP[31:0];
            end
            3'd1:
            begin
                a_half = cur_reg.hash[63:32];
                b_half = RECIP[31:0];
            end
            3'd2:
            begin
                a_half = cur_reg.hash[31:0];
                b_half = RECIP[63:32];
            end
            3'd3:
            begin
                a_half = cur_reg.hash[63:32];
                b_half = RECIP[63:32];
            end
            default:
            begin
                a_half = acc_reg[95:64];
                b_half = CAP32;
            end
        endcase
        prod = a_half * b_half;
        case (step_reg)
            3'd0:       prod_wide = {64'd0, prod};
            3'd1, 3'd2: prod_wide = {32'd0, prod, 32'd0};
            3'd3:       prod_wide = {prod, 64'd0};
            default:    prod_wide = 128'd0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        steps_next  = steps_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rlo_next    = rlo_reg;
        rhi_next    = rhi_reg;
        pop         = 1'b0;
        wr_en       = 1'b0;
        wr_word     = {1'b1, cur_reg.key_high, cur_reg.key_low,
                       cur_reg.value_high, cur_reg.value_low};
        case (state_reg)
            BE_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_word  = '0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IW'(CAPACITY - 1))
                begin
                    idx_next   = '0;
                    state_next = BE_IDLE;
                end
            end
            BE_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cur_next = job;
                    rlo_next = 64'd0;
                    rhi_next = 64'd0;
                    if (job.cmd == CMD_REJECT)
                    begin
                        status_next = ST_REJECTED;
                        done_next   = 1'b1;
                    end
                    else if (job.cmd == CMD_MISS)
                    begin
                        status_next = ST_NOT_FOUND;
                        done_next   = 1'b1;
                    end
                    else if ((CAPACITY & (CAPACITY - 1)) == 0)
                    begin
                        idx_next   = job.hash[IW-1:0];
                        steps_next = '0;
                        state_next = BE_READ;
                    end
                    else
                    begin
                        acc_next   = 128'd0;
                        step_next  = 3'd0;
                        state_next = BE_HOME;
                    end
                end
            end
            BE_HOME:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg < 3'd4)
                begin
                    acc_next = acc_reg + prod_wide;
                end
                else if (step_reg == 3'd4)
                begin
                    rem_next = cur_reg.hash[31:0] - prod[31:0];
                end
                else
                begin
                    idx_next   = (rem_reg >= CAP32) ? IW'(rem_reg - CAP32) : IW'(rem_reg);
                    steps_next = '0;
                    state_next = BE_READ;
                end
            end
            BE_READ:
            begin
                state_next = BE_CHECK;
            end
            BE_CHECK:
            begin
                state_next = BE_READ;
                if (!rd_data[256])
                begin
                    if (cur_reg.cmd == CMD_LOOKUP)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else if (count_reg < CNTW'(max_entries))
                    begin
                        wr_en       = 1'b1;
                        count_next  = count_reg + 1'b1;
                        status_next = ST_INSERTED;
                    end
                    else
                    begin
                        status_next = ST_REJECTED;
                    end
                    state_next = BE_DONE;
                end
                else if (rd_data[255:128] == {cur_reg.key_high, cur_reg.key_low})
                begin
                    if (cur_reg.cmd == CMD_LOOKUP)
                    begin
                        status_next = ST_FOUND;
                        rhi_next    = rd_data[127:64];
                        rlo_next    = rd_data[63:0];
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        status_next = ST_UPDATED;
                    end
                    state_next = BE_DONE;
                end
                else if (steps_reg == CW'(CAPACITY - 1))
                begin
                    status_next = (cur_reg.cmd == CMD_LOOKUP) ? ST_NOT_FOUND
                                                              : ST_REJECTED;
                    state_next  = BE_DONE;
                end
                else
                begin
                    steps_next = steps_reg + 1'b1;
                    idx_next   = (idx_reg == IW'(CAPACITY - 1)) ? '0 : idx_reg + 1'b1;
                end
            end
            BE_DONE:
            begin
                done_next  = 1'b1;
                state_next = BE_IDLE;
            end
            default:
            begin
                state_next = BE_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/linear_probe_hash_table_core.sv -----
// ============================================================================
// linear_probe_hash_table_core
// Open-addressing key/value table with linear probing and a splitmix64 hash.
// ============================================================================
// Channel   Direction  Handshake            Payload
// request   in         start / busy         operation, key_*, value_*
// result    out        done strobe          status, result_*
// config    in         cfg_valid/cfg_ready  cfg_data (max_entries)
//
// The front holds busy after each accepted request for the two mixing rounds
// on a shared 32x32 multiplier, and longer while the queue is full. The back
// probes each slot in a read state and then a check state on the slot memory,
// after a reciprocal reduction when the capacity is not a power of two.
// After reset a clearing pass marks every slot empty, and requests taken
// meanwhile wait in the queue. Results cannot be stalled.
// ============================================================================
module linear_probe_hash_table_core
    import lpht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [63:0] key_low,
    input  logic [63:0] key_high,
    input  logic [63:0] value_low,
    input  logic [63:0] value_high,
    output logic        done,
    output logic [2:0]  status,
    output logic [63:0] result_low,
    output logic [63:0] result_high,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data
);

    logic [9:0] max_entries_reg;
    logic       push, full, pop, empty;
    job_t       push_job, pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_entries_reg <= cfg_data;
        end
    end

    lpht_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .key_low    (key_low),
        .key_high   (key_high),
        .value_low  (value_low),
        .value_high (value_high),
        .push       (push),
        .job        (push_job),
        .full       (full)
    );

    lpht_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_job),
        .empty     (empty)
    );

    lpht_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_entries (max_entries_reg),
        .empty       (empty),
        .job         (pop_job),
        .pop         (pop),
        .done        (done),
        .status      (status),
        .result_low  (result_low),
        .result_high (result_high)
    );

endmodule
